[hw/rtl/quaternion_pose_composer_top_macros.svh]
// ----------------------------------------------------------------------------
// Quaternion pose composer assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_POSE_COMPOSER_TOP_MACROS_SVH
`define QUATERNION_POSE_COMPOSER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// checked outside reset
`define QPC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("qpc assertion failed");
// checked on every edge, reset included
`define QPC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("qpc assertion failed");
`else
`define QPC_ASSERT(lbl, clk, rst_n, prop)
`define QPC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[hw/rtl/qpc_pkg.sv]
// ----------------------------------------------------------------------------
// Quaternion pose composer package
// Formats, request/response payloads, step microcode and saturation helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qpc_pkg;

  localparam int unsigned POS_W          = 32;
  localparam int unsigned QUAT_W         = 16;
  localparam int unsigned QUAT_FRAC_BITS = 14;
  localparam int unsigned PROD_W         = POS_W + QUAT_W;
  localparam int unsigned ACC_W          = PROD_W + 2;
  localparam int unsigned CW_W           = 36;
  localparam int unsigned SUM_W          = 38;
  localparam int unsigned NUM_STEPS      = 31;
  localparam int unsigned ROT_STEPS      = 15;
  localparam int unsigned STEP_W         = $clog2(NUM_STEPS);

  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_COMPOSE = 2'd1;
  localparam logic [1:0] MODE_POINT   = 2'd2;

  localparam logic [1:0] A_X = 2'd0;
  localparam logic [1:0] A_Y = 2'd1;
  localparam logic [1:0] A_Z = 2'd2;
  localparam logic [1:0] A_W = 2'd3;

  localparam logic [STEP_W-1:0] LAST_COMPOSE = STEP_W'(NUM_STEPS - 1);
  localparam logic [STEP_W-1:0] LAST_POINT   = STEP_W'(ROT_STEPS - 1);

  localparam logic signed [QUAT_W-1:0] QUAT_ONE = QUAT_W'(1 << QUAT_FRAC_BITS);

  localparam logic signed [ACC_W-1:0] HALF_T = ACC_W'(1) <<< (QUAT_FRAC_BITS - 2);
  localparam logic signed [ACC_W-1:0] HALF_Q = ACC_W'(1) <<< (QUAT_FRAC_BITS - 1);

  localparam logic signed [ACC_W-1:0] POS_HI  = (ACC_W'(1) <<< (POS_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] POS_LO  = -POS_HI - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] QUAT_HI = (ACC_W'(1) <<< (QUAT_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] QUAT_LO = -QUAT_HI - ACC_W'(1);

  typedef struct packed {
    logic [1:0]              mode;
    logic signed [POS_W-1:0]  in_pos_x;
    logic signed [POS_W-1:0]  in_pos_y;
    logic signed [POS_W-1:0]  in_pos_z;
    logic signed [QUAT_W-1:0] in_quat_x;
    logic signed [QUAT_W-1:0] in_quat_y;
    logic signed [QUAT_W-1:0] in_quat_z;
    logic signed [QUAT_W-1:0] in_quat_w;
  } req_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  out_pos_x;
    logic signed [POS_W-1:0]  out_pos_y;
    logic signed [POS_W-1:0]  out_pos_z;
    logic signed [QUAT_W-1:0] out_quat_x;
    logic signed [QUAT_W-1:0] out_quat_y;
    logic signed [QUAT_W-1:0] out_quat_z;
    logic signed [QUAT_W-1:0] out_quat_w;
  } rsp_t;

  typedef enum logic [3:0] {
    B_VX, B_VY, B_VZ, B_TX, B_TY, B_TZ, B_QX, B_QY, B_QZ, B_QW
  } opb_e;

  typedef enum logic [1:0] {
    WB_T, WB_C, WB_W, WB_Q
  } wb_e;

  typedef enum logic [2:0] {
    S_IDLE, S_RUN, S_DRAIN, S_FIN_R, S_FIN_P, S_DONE
  } seq_state_e;

  typedef struct packed {
    logic [1:0] a_sel;
    opb_e       b_sel;
    logic       neg;
    logic       first;
    logic       last;
    wb_e        wb;
    logic [1:0] idx;
  } step_t;

  typedef struct packed {
    logic  issue;
    step_t step;
    logic  fin_r;
    logic  fin_p;
    logic  push;
  } seq_ctrl_t;

  typedef struct packed {
    logic                    valid;
    wb_e                     wb;
    logic [1:0]              idx;
    logic signed [ACC_W-1:0] value;
  } mac_wb_t;

  function automatic step_t mk_step(input logic [1:0] a, input opb_e b, input logic neg,
                                    input logic first, input logic last, input wb_e wb,
                                    input logic [1:0] idx);
    step_t s;
    s.a_sel = a;
    s.b_sel = b;
    s.neg   = neg;
    s.first = first;
    s.last  = last;
    s.wb    = wb;
    s.idx   = idx;
    return s;
  endfunction

  // rotation: t = 2(qv x v), c = qv x t, w = qw*t; then Hamilton stored * input
  function automatic step_t step_ctrl(input logic [STEP_W-1:0] n);
    step_t s;
    case (n)
      5'd0:    s = mk_step(A_Y, B_VZ, 1'b0, 1'b1, 1'b0, WB_T, 2'd0);
      5'd1:    s = mk_step(A_Z, B_VY, 1'b1, 1'b0, 1'b1, WB_T, 2'd0);
      5'd2:    s = mk_step(A_Z, B_VX, 1'b0, 1'b1, 1'b0, WB_T, 2'd1);
      5'd3:    s = mk_step(A_X, B_VZ, 1'b1, 1'b0, 1'b1, WB_T, 2'd1);
      5'd4:    s = mk_step(A_X, B_VY, 1'b0, 1'b1, 1'b0, WB_T, 2'd2);
      5'd5:    s = mk_step(A_Y, B_VX, 1'b1, 1'b0, 1'b1, WB_T, 2'd2);
      5'd6:    s = mk_step(A_Z, B_TY, 1'b1, 1'b1, 1'b0, WB_C, 2'd0);
      5'd7:    s = mk_step(A_Y, B_TZ, 1'b0, 1'b0, 1'b1, WB_C, 2'd0);
      5'd8:    s = mk_step(A_Z, B_TX, 1'b0, 1'b1, 1'b0, WB_C, 2'd1);
      5'd9:    s = mk_step(A_X, B_TZ, 1'b1, 1'b0, 1'b1, WB_C, 2'd1);
      5'd10:   s = mk_step(A_X, B_TY, 1'b0, 1'b1, 1'b0, WB_C, 2'd2);
      5'd11:   s = mk_step(A_Y, B_TX, 1'b1, 1'b0, 1'b1, WB_C, 2'd2);
      5'd12:   s = mk_step(A_W, B_TX, 1'b0, 1'b1, 1'b1, WB_W, 2'd0);
      5'd13:   s = mk_step(A_W, B_TY, 1'b0, 1'b1, 1'b1, WB_W, 2'd1);
      5'd14:   s = mk_step(A_W, B_TZ, 1'b0, 1'b1, 1'b1, WB_W, 2'd2);
      5'd15:   s = mk_step(A_W, B_QX, 1'b0, 1'b1, 1'b0, WB_Q, 2'd0);
      5'd16:   s = mk_step(A_X, B_QW, 1'b0, 1'b0, 1'b0, WB_Q, 2'd0);
      5'd17:   s = mk_step(A_Y, B_QZ, 1'b0, 1'b0, 1'b0, WB_Q, 2'd0);
      5'd18:   s = mk_step(A_Z, B_QY, 1'b1, 1'b0, 1'b1, WB_Q, 2'd0);
      5'd19:   s = mk_step(A_W, B_QY, 1'b0, 1'b1, 1'b0, WB_Q, 2'd1);
      5'd20:   s = mk_step(A_X, B_QZ, 1'b1, 1'b0, 1'b0, WB_Q, 2'd1);
      5'd21:   s = mk_step(A_Y, B_QW, 1'b0, 1'b0, 1'b0, WB_Q, 2'd1);
      5'd22:   s = mk_step(A_Z, B_QX, 1'b0, 1'b0, 1'b1, WB_Q, 2'd1);
      5'd23:   s = mk_step(A_W, B_QZ, 1'b0, 1'b1, 1'b0, WB_Q, 2'd2);
      5'd24:   s = mk_step(A_X, B_QY, 1'b0, 1'b0, 1'b0, WB_Q, 2'd2);
      5'd25:   s = mk_step(A_Y, B_QX, 1'b1, 1'b0, 1'b0, WB_Q, 2'd2);
      5'd26:   s = mk_step(A_Z, B_QW, 1'b0, 1'b0, 1'b1, WB_Q, 2'd2);
      5'd27:   s = mk_step(A_W, B_QW, 1'b0, 1'b1, 1'b0, WB_Q, 2'd3);
      5'd28:   s = mk_step(A_X, B_QX, 1'b1, 1'b0, 1'b0, WB_Q, 2'd3);
      5'd29:   s = mk_step(A_Y, B_QY, 1'b1, 1'b0, 1'b0, WB_Q, 2'd3);
      5'd30:   s = mk_step(A_Z, B_QZ, 1'b1, 1'b0, 1'b1, WB_Q, 2'd3);
      default: s = mk_step(A_X, B_VX, 1'b0, 1'b1, 1'b0, WB_T, 2'd0);
    endcase
    return s;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] x);
    logic signed [POS_W-1:0] r;
    if (x > POS_HI) begin
      r = POS_W'(POS_HI);
    end else if (x < POS_LO) begin
      r = POS_W'(POS_LO);
    end else begin
      r = POS_W'(x);
    end
    return r;
  endfunction

  function automatic logic signed [QUAT_W-1:0] sat_quat(input logic signed [ACC_W-1:0] x);
    logic signed [QUAT_W-1:0] r;
    if (x > QUAT_HI) begin
      r = QUAT_W'(QUAT_HI);
    end else if (x < QUAT_LO) begin
      r = QUAT_W'(QUAT_LO);
    end else begin
      r = QUAT_W'(x);
    end
    return r;
  endfunction

endpackage

[hw/rtl/qpc_stream_if.sv]
// ----------------------------------------------------------------------------
// Quaternion pose composer stream channel
// Valid/ready channel carrying one request or response payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface qpc_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

[hw/rtl/quaternion_pose_composer_top.sv]
// ----------------------------------------------------------------------------
// Quaternion pose composer
// Keeps a world pose (Q16.16 position, Q1.14 quaternion) of a kinematic chain
// and loads, composes onto or transforms a point with it.
// ----------------------------------------------------------------------------
// One request at a time. A load or unused mode goes straight to the response
// stage; a point transform or a pose composition runs the microcode: a single
// registered 16x32 multiplier with its accumulator works through the 15
// rotation products and, for a composition, the 16 Hamilton products one per
// cycle, followed by a drain state and the two final saturating sums. A
// finished response sits in an output register, so the next request is taken
// as soon as the result has moved there; a load or composition stores its pose then.
`timescale 1ns / 1ps

`include "quaternion_pose_composer_top_macros.svh"

module quaternion_pose_composer_top
  import qpc_pkg::*;
(
  input logic          clk_i,
  input logic          rst_ni,
  qpc_stream_if.sink   req_i,
  qpc_stream_if.source rsp_o
);

  logic accept;
  logic out_free;
  logic seq_ready;

  seq_ctrl_t ctrl;
  mac_wb_t   wb;

  req_t req_q;
  rsp_t rsp_q;
  logic rsp_valid_q;

  logic signed [POS_W-1:0]  world_pos_q  [3];
  logic signed [QUAT_W-1:0] world_quat_q [4];
  logic signed [POS_W-1:0]  res_pos_q    [3];
  logic signed [QUAT_W-1:0] res_quat_q   [4];
  logic signed [POS_W-1:0]  t_q          [3];
  logic signed [CW_W-1:0]   c_q          [3];
  logic signed [CW_W-1:0]   w_q          [3];
  logic signed [POS_W-1:0]  r_q          [3];

  logic signed [POS_W-1:0]  in_pos  [3];
  logic signed [QUAT_W-1:0] in_quat [4];
  logic signed [QUAT_W-1:0] in_quat_a [4];
  logic signed [POS_W-1:0]  in_pos_a  [3];
  logic signed [QUAT_W-1:0] op_a;
  logic signed [POS_W-1:0]  op_b;

  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = seq_ready;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  assign in_pos[0]  = req_q.in_pos_x;
  assign in_pos[1]  = req_q.in_pos_y;
  assign in_pos[2]  = req_q.in_pos_z;
  assign in_quat[0] = req_q.in_quat_x;
  assign in_quat[1] = req_q.in_quat_y;
  assign in_quat[2] = req_q.in_quat_z;
  assign in_quat[3] = req_q.in_quat_w;

  assign in_pos_a[0]  = req_i.data.in_pos_x;
  assign in_pos_a[1]  = req_i.data.in_pos_y;
  assign in_pos_a[2]  = req_i.data.in_pos_z;
  assign in_quat_a[0] = req_i.data.in_quat_x;
  assign in_quat_a[1] = req_i.data.in_quat_y;
  assign in_quat_a[2] = req_i.data.in_quat_z;
  assign in_quat_a[3] = req_i.data.in_quat_w;

  qpc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .mode_i     (req_i.data.mode),
    .out_free_i (out_free),
    .ready_o    (seq_ready),
    .ctrl_o     (ctrl)
  );

  assign op_a = world_quat_q[ctrl.step.a_sel];

  always_comb begin
    case (ctrl.step.b_sel)
      B_VX:    op_b = in_pos[0];
      B_VY:    op_b = in_pos[1];
      B_VZ:    op_b = in_pos[2];
      B_TX:    op_b = t_q[0];
      B_TY:    op_b = t_q[1];
      B_TZ:    op_b = t_q[2];
      B_QX:    op_b = POS_W'(in_quat[0]);
      B_QY:    op_b = POS_W'(in_quat[1]);
      B_QZ:    op_b = POS_W'(in_quat[2]);
      B_QW:    op_b = POS_W'(in_quat[3]);
      default: op_b = '0;
    endcase
  end

  qpc_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (ctrl.issue),
    .step_i  (ctrl.step),
    .a_i     (op_a),
    .b_i     (op_b),
    .wb_o    (wb)
  );

  // working registers and pending result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i.data;
      for (int i = 0; i < 3; i++) begin
        res_pos_q[i] <= (req_i.data.mode == MODE_LOAD) ? in_pos_a[i] : world_pos_q[i];
      end
      for (int i = 0; i < 4; i++) begin
        res_quat_q[i] <= (req_i.data.mode == MODE_LOAD) ? in_quat_a[i] : world_quat_q[i];
      end
    end
    if (wb.valid) begin
      case (wb.wb)
        WB_T: begin
          for (int i = 0; i < 3; i++) begin
            if (wb.idx == 2'(i)) t_q[i] <= sat_pos(wb.value);
          end
        end
        WB_C: begin
          for (int i = 0; i < 3; i++) begin
            if (wb.idx == 2'(i)) c_q[i] <= CW_W'(wb.value);
          end
        end
        WB_W: begin
          for (int i = 0; i < 3; i++) begin
            if (wb.idx == 2'(i)) w_q[i] <= CW_W'(wb.value);
          end
        end
        WB_Q: begin
          for (int i = 0; i < 4; i++) begin
            if (wb.idx == 2'(i)) res_quat_q[i] <= sat_quat(wb.value);
          end
        end
        default: ;
      endcase
    end
    if (ctrl.fin_r) begin
      for (int i = 0; i < 3; i++) begin
        r_q[i] <= sat_pos(ACC_W'(SUM_W'(in_pos[i]) + SUM_W'(w_q[i]) + SUM_W'(c_q[i])));
      end
    end
    if (ctrl.fin_p) begin
      for (int i = 0; i < 3; i++) begin
        res_pos_q[i] <= sat_pos(ACC_W'(SUM_W'(r_q[i]) + SUM_W'(world_pos_q[i])));
      end
    end
    if (ctrl.push) begin
      rsp_q.out_pos_x  <= res_pos_q[0];
      rsp_q.out_pos_y  <= res_pos_q[1];
      rsp_q.out_pos_z  <= res_pos_q[2];
      rsp_q.out_quat_x <= res_quat_q[0];
      rsp_q.out_quat_y <= res_quat_q[1];
      rsp_q.out_quat_z <= res_quat_q[2];
      rsp_q.out_quat_w <= res_quat_q[3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        world_pos_q[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        world_quat_q[i] <= '0;
      end
      world_quat_q[3] <= QUAT_ONE;
    end else begin
      if (ctrl.push) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      if (ctrl.push && (req_q.mode == MODE_LOAD || req_q.mode == MODE_COMPOSE)) begin
        for (int i = 0; i < 3; i++) begin
          world_pos_q[i] <= res_pos_q[i];
        end
        for (int i = 0; i < 4; i++) begin
          world_quat_q[i] <= res_quat_q[i];
        end
      end
    end
  end

  `QPC_ASSERT(a_point_keeps_pose, clk_i, rst_ni, (ctrl.push && req_q.mode == MODE_POINT) |=> ($stable(world_pos_q[0]) && $stable(world_quat_q[3])))
  `QPC_ASSERT(a_busy_after_accept, clk_i, rst_ni, accept |=> !req_i.ready)
  `QPC_ASSERT_ALWAYS(a_no_rsp_in_reset, clk_i, !rst_ni |-> !rsp_valid_q)

endmodule

[hw/rtl/qpc_seq.sv]
// ----------------------------------------------------------------------------
// Quaternion pose composer sequencer
// Steps the shared multiply-accumulate unit through the microcode (point and
// compose only), then the final sums and the hand-off to the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "quaternion_pose_composer_top_macros.svh"

module qpc_seq
  import qpc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  logic [1:0] mode_i,
  input  logic      out_free_i,
  output logic      ready_o,
  output seq_ctrl_t ctrl_o
);

  seq_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [STEP_W-1:0] end_q, end_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    end_d   = end_q;
    case (state_q)
      S_IDLE: begin
        if (accept_i) begin
          step_d = '0;
          if (mode_i == MODE_COMPOSE) begin
            state_d = S_RUN;
            end_d   = LAST_COMPOSE;
          end else if (mode_i == MODE_POINT) begin
            state_d = S_RUN;
            end_d   = LAST_POINT;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_RUN: begin
        if (step_q == end_q) begin
          state_d = S_DRAIN;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      S_DRAIN: state_d = S_FIN_R;
      S_FIN_R: state_d = S_FIN_P;
      S_FIN_P: state_d = S_DONE;
      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ready_o      = 1'b0;
    ctrl_o       = '0;
    ctrl_o.step  = step_ctrl(step_q);
    case (state_q)
      S_IDLE:  ready_o      = 1'b1;
      S_RUN:   ctrl_o.issue = 1'b1;
      S_FIN_R: ctrl_o.fin_r = 1'b1;
      S_FIN_P: ctrl_o.fin_p = 1'b1;
      S_DONE:  ctrl_o.push  = out_free_i;
      default: ready_o      = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      end_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      end_q   <= end_d;
    end
  end

  `QPC_ASSERT(a_run_in_range, clk_i, rst_ni, state_q == S_RUN |-> step_q <= end_q)
  `QPC_ASSERT(a_compose_start, clk_i, rst_ni, (accept_i && mode_i == MODE_COMPOSE) |=> (state_q == S_RUN && step_q == '0 && end_q == LAST_COMPOSE))
  `QPC_ASSERT(a_fin_order, clk_i, rst_ni, ctrl_o.fin_p |-> $past(ctrl_o.fin_r))

endmodule

[hw/rtl/qpc_mac.sv]
// ----------------------------------------------------------------------------
// Quaternion pose composer multiply-accumulate unit
// Registered 16x32 signed product feeding a rounding accumulator; emits the
// rounded term on the last product of each sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qpc_mac
  import qpc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     issue_i,
  input  step_t                    step_i,
  input  logic signed [QUAT_W-1:0] a_i,
  input  logic signed [POS_W-1:0]  b_i,
  output mac_wb_t                  wb_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  base, term;
  step_t                    ctl_q;
  logic                     vld_q;

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
      ctl_q  <= step_i;
    end
    if (vld_q) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= issue_i;
    end
  end

  // rounding offset seeds the first product of each sum
  always_comb begin
    if (ctl_q.first) begin
      base = (ctl_q.wb == WB_T) ? HALF_T : HALF_Q;
    end else begin
      base = acc_q;
    end
    term  = ACC_W'(prod_q);
    acc_d = ctl_q.neg ? (base - term) : (base + term);
  end

  always_comb begin
    wb_o.valid = vld_q && ctl_q.last;
    wb_o.wb    = ctl_q.wb;
    wb_o.idx   = ctl_q.idx;
    if (ctl_q.wb == WB_T) begin
      wb_o.value = acc_d >>> (QUAT_FRAC_BITS - 1);
    end else begin
      wb_o.value = acc_d >>> QUAT_FRAC_BITS;
    end
  end

endmodule

[tb/sv/tb_quaternion_pose_composer_top.sv]
// ----------------------------------------------------------------------------
// Quaternion pose composer testbench
// Drives load, compose, point and unused-mode requests, first directed at the
// field extremes, rotation cases and saturation, then random pose chains under
// three idle patterns. An in-bench pose model predicts every response, which
// is compared field by field in request order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_quaternion_pose_composer_top;
  import qpc_pkg::*;

  localparam int          QF          = int'(QUAT_FRAC_BITS);
  localparam int          SETTLE      = 40;
  localparam longint      TIMEOUT_NS  = 64'd5_000_000;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  localparam logic signed [POS_W-1:0]  POS_MAX  = 32'sh7fff_ffff;
  localparam logic signed [POS_W-1:0]  POS_MIN  = 32'sh8000_0000;
  localparam logic signed [POS_W-1:0]  POS_ONE  = 32'sd65536;
  localparam logic signed [QUAT_W-1:0] QMAX     = 16'sh7fff;
  localparam logic signed [QUAT_W-1:0] QMIN     = 16'sh8000;
  localparam logic signed [QUAT_W-1:0] QHALF_RT = 16'sd11585;

  logic clk_i;
  logic rst_ni;

  qpc_stream_if #(.payload_t(req_t)) req_if ();
  qpc_stream_if #(.payload_t(rsp_t)) rsp_if ();

  quaternion_pose_composer_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatch_count;
  rsp_t        expected_poses[$];

  longint wp_x, wp_y, wp_z;
  longint wq_x, wq_y, wq_z, wq_w;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_quaternion_pose_composer_top failed");
    $finish;
  end

  function automatic longint round_shift(input longint x, input int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_to(input longint x, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // Applies one request to the model pose and returns the response it gives.
  function automatic rsp_t compose_world_pose(input req_t r);
    rsp_t   o;
    longint vx, vy, vz, ix, iy, iz, iw;
    longint tx, ty, tz, cx, cy, cz;
    longint px, py, pz, qx, qy, qz, qw;
    vx = longint'($signed(r.in_pos_x));
    vy = longint'($signed(r.in_pos_y));
    vz = longint'($signed(r.in_pos_z));
    ix = longint'($signed(r.in_quat_x));
    iy = longint'($signed(r.in_quat_y));
    iz = longint'($signed(r.in_quat_z));
    iw = longint'($signed(r.in_quat_w));
    px = wp_x; py = wp_y; pz = wp_z;
    qx = wq_x; qy = wq_y; qz = wq_z; qw = wq_w;
    case (r.mode)
      MODE_LOAD: begin
        px = vx; py = vy; pz = vz;
        qx = ix; qy = iy; qz = iz; qw = iw;
      end
      MODE_COMPOSE, MODE_POINT: begin
        // t = 2 (qv x v), then v + qw t + qv x t
        tx = clamp_to(round_shift(wq_y * vz - wq_z * vy, QF - 1), 32);
        ty = clamp_to(round_shift(wq_z * vx - wq_x * vz, QF - 1), 32);
        tz = clamp_to(round_shift(wq_x * vy - wq_y * vx, QF - 1), 32);
        cx = round_shift(wq_y * tz - wq_z * ty, QF);
        cy = round_shift(wq_z * tx - wq_x * tz, QF);
        cz = round_shift(wq_x * ty - wq_y * tx, QF);
        px = clamp_to(clamp_to(vx + round_shift(wq_w * tx, QF) + cx, 32) + wp_x, 32);
        py = clamp_to(clamp_to(vy + round_shift(wq_w * ty, QF) + cy, 32) + wp_y, 32);
        pz = clamp_to(clamp_to(vz + round_shift(wq_w * tz, QF) + cz, 32) + wp_z, 32);
        if (r.mode == MODE_COMPOSE) begin
          qx = clamp_to(round_shift(wq_w*ix + wq_x*iw + wq_y*iz - wq_z*iy, QF), 16);
          qy = clamp_to(round_shift(wq_w*iy - wq_x*iz + wq_y*iw + wq_z*ix, QF), 16);
          qz = clamp_to(round_shift(wq_w*iz + wq_x*iy - wq_y*ix + wq_z*iw, QF), 16);
          qw = clamp_to(round_shift(wq_w*iw - wq_x*ix - wq_y*iy - wq_z*iz, QF), 16);
        end
      end
      default: begin
      end
    endcase
    if (r.mode == MODE_LOAD || r.mode == MODE_COMPOSE) begin
      wp_x = px; wp_y = py; wp_z = pz;
      wq_x = qx; wq_y = qy; wq_z = qz; wq_w = qw;
    end
    o.out_pos_x  = 32'(px);
    o.out_pos_y  = 32'(py);
    o.out_pos_z  = 32'(pz);
    o.out_quat_x = 16'(qx);
    o.out_quat_y = 16'(qy);
    o.out_quat_z = 16'(qz);
    o.out_quat_w = 16'(qw);
    return o;
  endfunction

  function automatic req_t mk_request(input logic [1:0] mode,
                                      input logic signed [POS_W-1:0] x,
                                      input logic signed [POS_W-1:0] y,
                                      input logic signed [POS_W-1:0] z,
                                      input logic signed [QUAT_W-1:0] qx,
                                      input logic signed [QUAT_W-1:0] qy,
                                      input logic signed [QUAT_W-1:0] qz,
                                      input logic signed [QUAT_W-1:0] qw);
    req_t r;
    r.mode      = mode;
    r.in_pos_x  = x;
    r.in_pos_y  = y;
    r.in_pos_z  = z;
    r.in_quat_x = qx;
    r.in_quat_y = qy;
    r.in_quat_z = qz;
    r.in_quat_w = qw;
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] rand_pos();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
  endfunction

  // mostly small components (each within +-9459), sometimes anything
  function automatic logic signed [QUAT_W-1:0] rand_quat();
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 18918)) - 9459);
  endfunction

  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r = mk_request(MODE_COMPOSE, rand_pos(), rand_pos(), rand_pos(),
                   rand_quat(), rand_quat(), rand_quat(), rand_quat());
    if (pick < 10) begin
      r.mode = MODE_LOAD;
    end else if (pick < 55) begin
      r.mode = MODE_COMPOSE;
    end else if (pick < 85) begin
      r.mode = MODE_POINT;
    end else if (pick < 92) begin
      r.mode = MODE_UNUSED;
    end else begin
      r.mode      = 2'($urandom);
      r.in_pos_x  = $urandom;
      r.in_pos_y  = $urandom;
      r.in_pos_z  = $urandom;
      r.in_quat_x = 16'($urandom);
      r.in_quat_y = 16'($urandom);
      r.in_quat_z = 16'($urandom);
      r.in_quat_w = 16'($urandom);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_request(input req_t r);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    expected_poses.push_back(compose_world_pose(r));
  endtask

  task automatic wait_all_responses();
    req_if.valid <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // receiver side
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    rsp_t want;
    rsp_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (expected_poses.size() == 0) begin
        report_mismatch("response with no request pending", 0, 0);
      end else begin
        want = expected_poses.pop_front();
        if (got.out_pos_x !== want.out_pos_x)
          report_mismatch("out_pos_x", got.out_pos_x, want.out_pos_x);
        if (got.out_pos_y !== want.out_pos_y)
          report_mismatch("out_pos_y", got.out_pos_y, want.out_pos_y);
        if (got.out_pos_z !== want.out_pos_z)
          report_mismatch("out_pos_z", got.out_pos_z, want.out_pos_z);
        if (got.out_quat_x !== want.out_quat_x)
          report_mismatch("out_quat_x", got.out_quat_x, want.out_quat_x);
        if (got.out_quat_y !== want.out_quat_y)
          report_mismatch("out_quat_y", got.out_quat_y, want.out_quat_y);
        if (got.out_quat_z !== want.out_quat_z)
          report_mismatch("out_quat_z", got.out_quat_z, want.out_quat_z);
        if (got.out_quat_w !== want.out_quat_w)
          report_mismatch("out_quat_w", got.out_quat_w, want.out_quat_w);
      end
    end
  end

  task automatic test_reset_pose();
    send_request(mk_request(MODE_POINT, POS_ONE + (POS_ONE >>> 1), -(POS_ONE <<< 1),
                            POS_ONE * 3, rand_quat(), rand_quat(), rand_quat(), rand_quat()));
    send_request(mk_request(MODE_UNUSED, rand_pos(), rand_pos(), rand_pos(),
                            rand_quat(), rand_quat(), rand_quat(), rand_quat()));
    wait_all_responses();
  endtask

  task automatic test_load_extremes();
    send_request(mk_request(MODE_LOAD, POS_MAX, POS_MAX, POS_MAX, QMAX, QMAX, QMAX, QMAX));
    send_request(mk_request(MODE_UNUSED, '0, '0, '0, '0, '0, '0, '0));
    send_request(mk_request(MODE_LOAD, POS_MIN, POS_MIN, POS_MIN, QMIN, QMIN, QMIN, QMIN));
    send_request(mk_request(MODE_UNUSED, POS_MAX, POS_MIN, POS_MAX, QMAX, QMIN, QMAX, QMIN));
    wait_all_responses();
  endtask

  task automatic test_rotation();
    // 90 degrees about z, twice, then points through the result
    send_request(mk_request(MODE_LOAD, POS_ONE * 100, '0, '0, '0, '0, QHALF_RT, QHALF_RT));
    send_request(mk_request(MODE_COMPOSE, POS_ONE, '0, '0, '0, '0, QHALF_RT, QHALF_RT));
    send_request(mk_request(MODE_POINT, '0, POS_ONE, '0, QMAX, QMIN, QMAX, QMIN));
    send_request(mk_request(MODE_POINT, POS_ONE, POS_ONE, -POS_ONE, '0, '0, '0, '0));
    wait_all_responses();
  endtask

  task automatic test_saturation();
    send_request(mk_request(MODE_LOAD, POS_MAX, POS_MIN, POS_MAX, '0, '0, '0, QUAT_ONE));
    send_request(mk_request(MODE_COMPOSE, POS_MAX, POS_MIN, POS_ONE, '0, '0, '0, QUAT_ONE));
    // unnormalized: all components near full scale
    send_request(mk_request(MODE_LOAD, POS_MIN, POS_ONE, POS_MAX, QMAX, QMAX, QMAX, QMAX));
    send_request(mk_request(MODE_COMPOSE, POS_MIN, POS_MAX, POS_MIN, QMIN, QMIN, QMIN, QMIN));
    send_request(mk_request(MODE_POINT, POS_MAX, POS_MAX, POS_MIN, '0, '0, '0, '0));
    send_request(mk_request(MODE_LOAD, '0, '0, '0, QMIN, QMAX, QMIN, QMAX));
    send_request(mk_request(MODE_COMPOSE, POS_MAX, POS_MIN, POS_MAX, QMIN, QMIN, QMAX, QMIN));
    send_request(mk_request(MODE_POINT, POS_MIN, POS_MIN, POS_MIN, QMAX, QMAX, QMAX, QMAX));
    send_request(mk_request(MODE_UNUSED, POS_MIN, POS_MAX, '0, QMIN, QMAX, '0, QMIN));
    wait_all_responses();
  endtask

  task automatic test_random_chains(input int unsigned count, input int unsigned send_pct,
                                    input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int unsigned i = 0; i < count; i++) begin
      send_request(random_request());
      if (i % 45 == 44) wait_all_responses();
    end
    wait_all_responses();
  endtask

  initial begin
    mismatch_count = 0;
    send_idle_pct  = 22;
    recv_idle_pct  = 84;
    wp_x = 0; wp_y = 0; wp_z = 0;
    wq_x = 0; wq_y = 0; wq_z = 0;
    wq_w = longint'($signed(QUAT_ONE));
    rst_ni       <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_pose();
    test_load_extremes();
    test_rotation();
    test_saturation();
    test_random_chains(135, 22, 84);
    test_random_chains(135, 84, 22);
    test_random_chains(130, 0, 0);

    if (mismatch_count == 0) begin
      $display("tb_quaternion_pose_composer_top passed");
    end else begin
      $display("tb_quaternion_pose_composer_top failed");
    end
    $finish;
  end

endmodule
